FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the sorted queue RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// Request codes and the cell control bundle of the sorted priority queue.
// ---------------------------------------------------------------------------
package spq_pkg;

  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_DEQUEUE = 1'b1;

  // Broadcast to every cell for one cycle.
  typedef struct packed {
    logic ins;  // insert the new entry, shift the tail one place back
    logic pop;  // drop the front entry, shift everything one place forward
  } cell_op_t;

endpackage

FILE: hdl/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell
// One slot of the sorted shift register: holds an item and its priority.
// ---------------------------------------------------------------------------
module spq_cell #(
  parameter int ITEM_WIDTH     = 32,
  parameter int PRIORITY_WIDTH = 16
) (
  input  logic                             clk,
  input  spq_pkg::cell_op_t                op,
  input  logic                             live,
  input  logic        [ITEM_WIDTH-1:0]     new_item,
  input  logic signed [PRIORITY_WIDTH-1:0] new_priority,
  input  logic        [ITEM_WIDTH-1:0]     left_item,
  input  logic signed [PRIORITY_WIDTH-1:0] left_priority,
  input  logic                             left_keep,
  input  logic        [ITEM_WIDTH-1:0]     right_item,
  input  logic signed [PRIORITY_WIDTH-1:0] right_priority,
  output logic        [ITEM_WIDTH-1:0]     item,
  output logic signed [PRIORITY_WIDTH-1:0] priority_val,
  output logic                             keep
);

  // Entry stays put when it is held and not later than the newcomer (FIFO on ties).
  assign keep = live && (priority_val <= new_priority);

  always_ff @(posedge clk) begin
    if (op.pop) begin
      item         <= right_item;
      priority_val <= right_priority;
    end else if (op.ins && !keep) begin
      if (left_keep) begin
        item         <= new_item;
        priority_val <= new_priority;
      end else begin
        item         <= left_item;
        priority_val <= left_priority;
      end
    end
  end

endmodule

FILE: hdl/stable_sorted_priority_queue_top.sv
// ---------------------------------------------------------------------------
// stable_sorted_priority_queue_top
// Stable sorted priority queue built as a systolic row of storage cells.
// ---------------------------------------------------------------------------
// Holds up to DEPTH entries, smallest priority at the front, equal
// priorities in arrival order. Each request (enqueue or dequeue) is one
// transaction on the input channel and yields exactly one result
// transaction describing the queue after the request. On an enqueue every
// cell compares its own priority against the incoming one in parallel and
// holds, loads the new entry, or takes its left neighbor's entry; on a
// dequeue every cell takes its right neighbor's entry. The result is offered
// the cycle after acceptance and a new request is taken every cycle the
// result side keeps up. Full enqueues are dropped (enqueue_dropped), empty
// dequeues are ignored (dequeue_ignored). No clearing pass runs after reset;
// slots beyond the occupancy are never observed.
`include "assert_macros.svh"

module stable_sorted_priority_queue_top #(
  parameter int DEPTH          = 16,
  parameter int ITEM_WIDTH     = 32,
  parameter int PRIORITY_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 req_type,
  input  logic        [ITEM_WIDTH-1:0]         new_item,
  input  logic signed [PRIORITY_WIDTH-1:0]     new_priority,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [ITEM_WIDTH-1:0]         head_item,
  output logic signed [PRIORITY_WIDTH-1:0]     head_priority,
  output logic        [$clog2(DEPTH+1)-1:0]    occupancy,
  output logic                                 queue_empty,
  output logic                                 enqueue_dropped,
  output logic                                 dequeue_ignored
);

  localparam int CW = $clog2(DEPTH + 1);

  logic        [CW-1:0]             count;
  logic        [CW-1:0]             count_next;
  logic                             accept;
  logic                             full;
  logic                             empty;
  logic                             do_ins;
  logic                             do_pop;
  spq_pkg::cell_op_t                op;

  logic        [ITEM_WIDTH-1:0]     cell_item     [DEPTH];
  logic signed [PRIORITY_WIDTH-1:0] cell_priority [DEPTH];
  logic        [DEPTH-1:0]          cell_keep;

  // Output slot frees up when empty or when its result is taken this cycle.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  assign do_ins = accept && (req_type == spq_pkg::REQ_ENQUEUE) && !full;
  assign do_pop = accept && (req_type == spq_pkg::REQ_DEQUEUE) && !empty;

  assign op.ins = do_ins;
  assign op.pop = do_pop;

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CW'(1);
    end else if (do_pop) begin
      count_next = count - CW'(1);
    end
  end

  // Cell row: cell 0 is the front; data flows back on insert, forward on pop.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic        [ITEM_WIDTH-1:0]     l_item;
    logic signed [PRIORITY_WIDTH-1:0] l_priority;
    logic                             l_keep;
    logic        [ITEM_WIDTH-1:0]     r_item;
    logic signed [PRIORITY_WIDTH-1:0] r_priority;

    if (i == 0) begin : g_front
      // Nothing ahead of the front: a front cell that yields takes the new entry.
      assign l_item     = '0;
      assign l_priority = '0;
      assign l_keep     = 1'b1;
    end else begin : g_mid
      assign l_item     = cell_item[i-1];
      assign l_priority = cell_priority[i-1];
      assign l_keep     = cell_keep[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign r_item     = '0;
      assign r_priority = '0;
    end else begin : g_inner
      assign r_item     = cell_item[i+1];
      assign r_priority = cell_priority[i+1];
    end

    spq_cell #(
      .ITEM_WIDTH     (ITEM_WIDTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_cell (
      .clk            (clk),
      .op             (op),
      .live           (count > CW'(i)),
      .new_item       (new_item),
      .new_priority   (new_priority),
      .left_item      (l_item),
      .left_priority  (l_priority),
      .left_keep      (l_keep),
      .right_item     (r_item),
      .right_priority (r_priority),
      .item           (cell_item[i]),
      .priority_val   (cell_priority[i]),
      .keep           (cell_keep[i])
    );
  end

  // Control and result flags. Queue state only moves on acceptance, which
  // with a pending result coincides with that result being taken, so the
  // head fields below can be read straight from the front cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      count           <= '0;
      out_valid       <= 1'b0;
      enqueue_dropped <= 1'b0;
      dequeue_ignored <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid       <= 1'b1;
        enqueue_dropped <= (req_type == spq_pkg::REQ_ENQUEUE) && full;
        dequeue_ignored <= (req_type == spq_pkg::REQ_DEQUEUE) && empty;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign occupancy     = count;
  assign queue_empty   = empty;
  assign head_item     = empty ? '0 : cell_item[0];
  assign head_priority = empty ? '0 : cell_priority[0];

  // ------------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------------
  `SPQ_ASSERT(a_count_bound, count <= CW'(DEPTH), "occupancy above DEPTH")

  `SPQ_ASSERT(a_enq_count, do_ins |=> (count == $past(count) + CW'(1)), "enqueue count slip")

  `SPQ_ASSERT(a_front_sorted, (count >= CW'(2)) |-> (cell_priority[0] <= cell_priority[1]), "front out of order")

  `SPQ_ASSERT(a_flags_exclusive, out_valid |-> !(enqueue_dropped && dequeue_ignored), "both flags set")

  `SPQ_ASSERT(a_result_follows, accept |=> out_valid, "accepted request gave no result")

endmodule

FILE: sim/stable_sorted_priority_queue_top_tb.sv
// ---------------------------------------------------------------------------
// stable_sorted_priority_queue_top_tb
// Self-checking bench for the stable sorted priority queue.
// ---------------------------------------------------------------------------
// A queue of pending requests feeds a clocked driver on the request channel.
// Every accepted request is run through a behavioral copy of the queue, and
// the predicted front entry, occupancy and flags wait in order for the
// result channel. A clocked monitor compares each result transaction field
// by field. Both sides idle at random, the result side also holds off once
// for a long stretch so the block backs up, and the request side pauses
// twice until every outstanding result has come back.
// ---------------------------------------------------------------------------
module stable_sorted_priority_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = 16;
  localparam int ITEM_WIDTH     = 32;
  localparam int PRIORITY_WIDTH = 16;
  localparam int OCC_WIDTH      = $clog2(DEPTH + 1);

  localparam int IDLE_PERCENT   = 34;  // chance of a gap per cycle, each side
  localparam int RANDOM_ITEMS   = 728;
  localparam int HOLD_CYCLES    = 60;  // long result-side stall
  localparam int HOLD_AFTER     = 400; // results seen before that stall
  localparam int CALM_START     = 700; // cycle window with no random idling
  localparam int CALM_END       = 1000;

  typedef logic [ITEM_WIDTH-1:0]            item_t;
  typedef logic signed [PRIORITY_WIDTH-1:0] prio_t;

  typedef struct {
    logic  kind;        // REQ_ENQUEUE or REQ_DEQUEUE
    item_t item;
    prio_t prio;
    bit    drain_first; // hold this one back until no result is outstanding
  } request_t;

  typedef struct {
    item_t                head_item;
    prio_t                head_priority;
    logic [OCC_WIDTH-1:0] occupancy;
    logic                 queue_empty;
    logic                 enqueue_dropped;
    logic                 dequeue_ignored;
  } queue_status_t;

  // DUT connections; every input has a known value from time zero
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 req_type = spq_pkg::REQ_ENQUEUE;
  item_t                new_item = '0;
  prio_t                new_priority = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  item_t                head_item;
  prio_t                head_priority;
  logic [OCC_WIDTH-1:0] occupancy;
  logic                 queue_empty;
  logic                 enqueue_dropped;
  logic                 dequeue_ignored;

  stable_sorted_priority_queue_top #(
    .DEPTH         (DEPTH),
    .ITEM_WIDTH    (ITEM_WIDTH),
    .PRIORITY_WIDTH(PRIORITY_WIDTH)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .new_item       (new_item),
    .new_priority   (new_priority),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .head_item      (head_item),
    .head_priority  (head_priority),
    .occupancy      (occupancy),
    .queue_empty    (queue_empty),
    .enqueue_dropped(enqueue_dropped),
    .dequeue_ignored(dequeue_ignored)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Shadow of the queue contents, kept in service order
  // ------------------------------------------------------------------------
  item_t       shadow_item [DEPTH];
  prio_t       shadow_prio [DEPTH];
  int unsigned shadow_count = 0;

  request_t      request_backlog[$];  // not yet offered to the DUT
  queue_status_t pending_status[$];   // predicted results, oldest first

  int unsigned fail_count    = 0;
  int unsigned cyc           = 0;
  int unsigned results_seen  = 0;
  int unsigned enq_accepted  = 0;
  int unsigned deq_accepted  = 0;
  int unsigned drops_seen    = 0;
  int unsigned ignores_seen  = 0;
  int unsigned full_seen     = 0;
  logic        calm;

  always @(posedge clk) cyc <= cyc + 1;
  assign calm = (cyc >= CALM_START) && (cyc < CALM_END);

  // Applies one request to the shadow queue and returns the status the DUT
  // should report afterwards. New entries go behind every entry of equal or
  // smaller priority, which keeps equal priorities first in, first out.
  function automatic queue_status_t apply_request(request_t req);
    queue_status_t st;
    int unsigned   pos;
    st = '{default: '0};
    if (req.kind == spq_pkg::REQ_ENQUEUE) begin
      if (shadow_count >= DEPTH) begin
        st.enqueue_dropped = 1'b1;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] <= req.prio) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_item[i] = shadow_item[i-1];
          shadow_prio[i] = shadow_prio[i-1];
        end
        shadow_item[pos] = req.item;
        shadow_prio[pos] = req.prio;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        st.dequeue_ignored = 1'b1;
      end else begin
        for (int i = 1; i < shadow_count; i++) begin
          shadow_item[i-1] = shadow_item[i];
          shadow_prio[i-1] = shadow_prio[i];
        end
        shadow_count--;
      end
    end
    if (shadow_count > 0) begin
      st.head_item     = shadow_item[0];
      st.head_priority = shadow_prio[0];
    end
    st.occupancy   = shadow_count[OCC_WIDTH-1:0];
    st.queue_empty = (shadow_count == 0);
    return st;
  endfunction

  // ------------------------------------------------------------------------
  // Request driver: accepts at the edge, then decides what to show next.
  // in_valid gets at most one nonblocking update per edge.
  // ------------------------------------------------------------------------
  request_t on_bus;

  always @(posedge clk) begin : request_driver
    bit offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_status.push_back(apply_request(on_bus));
        if (on_bus.kind == spq_pkg::REQ_ENQUEUE) enq_accepted++;
        else deq_accepted++;
      end
      // a transaction still waiting for ready keeps valid and payload as is
      if (!in_valid || in_ready) begin
        offer = 1'b0;
        if (request_backlog.size() != 0) begin
          if (request_backlog[0].drain_first && pending_status.size() != 0) offer = 1'b0;
          else if (!calm && $urandom_range(99) < IDLE_PERCENT) offer = 1'b0;
          else offer = 1'b1;
        end
        if (offer) begin
          on_bus = request_backlog.pop_front();
          req_type     <= on_bus.kind;
          new_item     <= on_bus.item;
          new_priority <= on_bus.prio;
        end
        in_valid <= offer;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Result monitor: checks against the oldest prediction, then picks
  // out_ready for the next cycle. The long hold is counted here.
  // ------------------------------------------------------------------------
  int unsigned hold_left = 0;

  always @(posedge clk) begin : result_monitor
    queue_status_t exp_st;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_status.size() == 0) begin
          $error("result transaction with no request outstanding");
          fail_count++;
        end else begin
          exp_st = pending_status.pop_front();
          if (head_item !== exp_st.head_item) begin
            $error("head_item expected %h got %h", exp_st.head_item, head_item);
            fail_count++;
          end
          if (head_priority !== exp_st.head_priority) begin
            $error("head_priority expected %0d got %0d", exp_st.head_priority, head_priority);
            fail_count++;
          end
          if (occupancy !== exp_st.occupancy) begin
            $error("occupancy expected %0d got %0d", exp_st.occupancy, occupancy);
            fail_count++;
          end
          if (queue_empty !== exp_st.queue_empty) begin
            $error("queue_empty expected %b got %b", exp_st.queue_empty, queue_empty);
            fail_count++;
          end
          if (enqueue_dropped !== exp_st.enqueue_dropped) begin
            $error("enqueue_dropped expected %b got %b",
                   exp_st.enqueue_dropped, enqueue_dropped);
            fail_count++;
          end
          if (dequeue_ignored !== exp_st.dequeue_ignored) begin
            $error("dequeue_ignored expected %b got %b",
                   exp_st.dequeue_ignored, dequeue_ignored);
            fail_count++;
          end
          if (exp_st.enqueue_dropped) drops_seen++;
          if (exp_st.dequeue_ignored) ignores_seen++;
          if (exp_st.occupancy == DEPTH) full_seen++;
        end
        // back the block up: the sender keeps offering meanwhile
        if (results_seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------
  function automatic void queue_request(logic kind, item_t item, prio_t prio,
                                        bit drain_first = 1'b0);
    request_t req;
    req.kind        = kind;
    req.item        = item;
    req.prio        = prio;
    req.drain_first = drain_first;
    request_backlog.push_back(req);
  endfunction

  // Often a handful of close values so ties are common, sometimes the
  // extremes, otherwise anything.
  function automatic prio_t random_priority();
    case ($urandom_range(9))
      0, 1, 2, 3: return prio_t'(int'($urandom_range(7)) - 4);
      4:          return $urandom_range(1) ? prio_t'(16'sh7FFF) : prio_t'(16'sh8000);
      default:    return prio_t'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int unsigned enq_percent;

    // Directed: empty dequeue, then fill with extremes and ties
    queue_request(spq_pkg::REQ_DEQUEUE, 32'h0000_0000, 16'sh0000);
    queue_request(spq_pkg::REQ_ENQUEUE, 32'hFFFF_FFFF, 16'sh7FFF);
    queue_request(spq_pkg::REQ_ENQUEUE, 32'h0000_0000, 16'sh8000);
    queue_request(spq_pkg::REQ_ENQUEUE, 32'h0000_0001, 16'sh0000);
    queue_request(spq_pkg::REQ_ENQUEUE, 32'h0000_0002, 16'sh0000);  // tie behind previous
    queue_request(spq_pkg::REQ_ENQUEUE, 32'h0000_0003, 16'shFFFF);
    queue_request(spq_pkg::REQ_ENQUEUE, 32'h0000_0004, 16'sh8000);  // tie with the front
    queue_request(spq_pkg::REQ_ENQUEUE, 32'h8000_0000, 16'sh7FFF);  // tie at the back
    queue_request(spq_pkg::REQ_ENQUEUE, 32'h5555_5555, 16'sh5555);
    queue_request(spq_pkg::REQ_ENQUEUE, 32'hAAAA_AAAA, 16'shAAAA);
    for (int i = 0; i < 7; i++)
      queue_request(spq_pkg::REQ_ENQUEUE, item_t'(32'h100 + i), 16'sh0001);
    // full now; this one must be dropped
    queue_request(spq_pkg::REQ_ENQUEUE, 32'hDEAD_BEEF, 16'sh8000);
    for (int i = 0; i < 4; i++)
      queue_request(spq_pkg::REQ_DEQUEUE, $urandom, prio_t'($urandom));

    // Random: phases that lean toward filling, draining or neither, so the
    // queue swings between full and empty with tied priorities in between
    enq_percent = 50;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0:       enq_percent = 80;
          1:       enq_percent = 20;
          default: enq_percent = 50;
        endcase
      end
      queue_request($urandom_range(99) < enq_percent ?
                      spq_pkg::REQ_ENQUEUE : spq_pkg::REQ_DEQUEUE,
                    $urandom, random_priority(), (i == 0) || (i == 350));
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (request_backlog.size() != 0 || in_valid || pending_status.size() != 0)
      @(posedge clk);
    // nothing outstanding; keep running to catch stray results
    repeat (10) @(posedge clk);

    $display("covered %0d enqueues and %0d dequeues, %0d results checked",
             enq_accepted, deq_accepted, results_seen);
    $display("queue full %0d times, %0d dropped enqueues, %0d ignored dequeues",
             full_seen, drops_seen, ignores_seen);
    if (fail_count == 0) begin
      $display("stable_sorted_priority_queue_top_tb OK");
    end else begin
      $display("stable_sorted_priority_queue_top_tb NOT OK");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run
  initial begin : watchdog
    #200000;
    $display("stable_sorted_priority_queue_top_tb NOT OK");
    $finish;
  end

endmodule
